### rtl/lswc_pkg.sv
// Shared constants for the line segment window clipper.
// Depends on nothing; every clipper module imports it.
`timescale 1ns / 1ps
`default_nettype none
package lswc_pkg;

  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned ClipSteps = 8;
  localparam int unsigned CfgIdxBits = 2;

  // Outcode bit positions.
  localparam int unsigned OcLeft   = 0;
  localparam int unsigned OcRight  = 1;
  localparam int unsigned OcBottom = 2;
  localparam int unsigned OcTop    = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] RegXMin = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegYMin = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegXMax = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegYMax = 2'd3;

endpackage : lswc_pkg
`default_nettype wire

### rtl/lswc_div.sv
// Pipelined restoring divider for the clip intersection quotient.
// Depends on lswc_pkg; one stage per quotient bit, sign applied at the end.
`timescale 1ns / 1ps
`default_nettype none
module lswc_div #(
  parameter int unsigned NumBits = 34,
  parameter int unsigned DenBits = 17,
  parameter int unsigned TagBits = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic [NumBits-1:0]     num_i,
  input  wire logic [DenBits-1:0]     den_i,
  input  wire logic                   neg_i,
  input  wire logic [TagBits-1:0]     tag_i,
  output logic                        valid_o,
  output logic signed [NumBits:0]     quot_o,
  output logic [TagBits-1:0]          tag_o
);
  import lswc_pkg::*;

  logic                 vld_q  [NumBits+1];
  logic [NumBits-1:0]   num_q  [NumBits+1];
  logic [DenBits:0]     rem_q  [NumBits+1];
  logic [NumBits-1:0]   quo_q  [NumBits+1];
  logic [DenBits-1:0]   den_q  [NumBits+1];
  logic                 neg_q  [NumBits+1];
  logic [TagBits-1:0]   tag_q  [NumBits+1];

  // Stage zero holds the raw operands.
  always_comb begin
    vld_q[0] = valid_i;
    num_q[0] = num_i;
    rem_q[0] = '0;
    quo_q[0] = '0;
    den_q[0] = den_i;
    neg_q[0] = neg_i;
    tag_q[0] = tag_i;
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < NumBits; s++) begin : g_stage
    logic [DenBits:0] trial;
    logic             fits;
    assign trial = {rem_q[s][DenBits-1:0], num_q[s][NumBits-1]};
    assign fits  = (trial >= {1'b0, den_q[s]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[s+1] <= {num_q[s][NumBits-2:0], 1'b0};
      rem_q[s+1] <= fits ? (trial - {1'b0, den_q[s]}) : trial;
      quo_q[s+1] <= {quo_q[s][NumBits-2:0], fits};
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
      tag_q[s+1] <= tag_q[s];
    end
  end

  logic signed [NumBits:0] mag;
  assign mag     = $signed({1'b0, quo_q[NumBits]});
  assign quot_o  = (den_q[NumBits] == '0) ? '0 : (neg_q[NumBits] ? -mag : mag);
  assign valid_o = vld_q[NumBits];
  assign tag_o   = tag_q[NumBits];

endmodule : lswc_div
`default_nettype wire

### rtl/lswc_step.sv
// One Cohen-Sutherland clip step: outcodes, decision, edge choice and move.
// Depends on lswc_pkg and lswc_div; registered between each phase.
`timescale 1ns / 1ps
`default_nettype none
module lswc_step #(
  parameter int unsigned CoordBits = lswc_pkg::CoordBitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic signed [CoordBits-1:0] x_min_i,
  input  wire logic signed [CoordBits-1:0] y_min_i,
  input  wire logic signed [CoordBits-1:0] x_max_i,
  input  wire logic signed [CoordBits-1:0] y_max_i,
  input  wire logic                        valid_i,
  input  wire logic                        done_i,
  input  wire logic                        acc_i,
  input  wire logic                        moved_i,
  input  wire logic signed [CoordBits-1:0] p0x_i,
  input  wire logic signed [CoordBits-1:0] p0y_i,
  input  wire logic signed [CoordBits-1:0] p1x_i,
  input  wire logic signed [CoordBits-1:0] p1y_i,
  output logic                             valid_o,
  output logic                             done_o,
  output logic                             acc_o,
  output logic                             moved_o,
  output logic signed [CoordBits-1:0]      p0x_o,
  output logic signed [CoordBits-1:0]      p0y_o,
  output logic signed [CoordBits-1:0]      p1x_o,
  output logic signed [CoordBits-1:0]      p1y_o
);
  import lswc_pkg::*;

  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned TW = 3 + 4 * CoordBits + 2 + CoordBits + 1;

  function automatic logic [3:0] outcode(input logic signed [CoordBits-1:0] x,
                                         input logic signed [CoordBits-1:0] y,
                                         input logic signed [CoordBits-1:0] xl,
                                         input logic signed [CoordBits-1:0] yl,
                                         input logic signed [CoordBits-1:0] xh,
                                         input logic signed [CoordBits-1:0] yh);
    logic [3:0] c;
    c = '0;
    c[OcTop]    = (y > yh);
    c[OcBottom] = (y < yl);
    c[OcRight]  = (x > xh);
    c[OcLeft]   = (x < xl);
    return c;
  endfunction

  // Phase one: outcodes and decision.
  logic [3:0] c0, c1, c;
  logic       now_acc, now_rej, sel_end, use_x;
  logic signed [CoordBits-1:0] edge_v, pe, po, qe, qo;
  assign c0      = outcode(p0x_i, p0y_i, x_min_i, y_min_i, x_max_i, y_max_i);
  assign c1      = outcode(p1x_i, p1y_i, x_min_i, y_min_i, x_max_i, y_max_i);
  assign now_acc = ((c0 | c1) == 4'd0);
  assign now_rej = ((c0 & c1) != 4'd0);
  assign sel_end = (c0 == 4'd0);
  assign c       = sel_end ? c1 : c0;
  assign use_x   = c[OcLeft] | c[OcRight];

  always_comb begin
    if (c[OcLeft]) begin
      edge_v = x_min_i;
    end else if (c[OcRight]) begin
      edge_v = x_max_i;
    end else if (c[OcBottom]) begin
      edge_v = y_min_i;
    end else begin
      edge_v = y_max_i;
    end
    // pe/po: moving point along/across the edge axis; qe/qo: other point.
    if (use_x) begin
      pe = sel_end ? p1x_i : p0x_i;
      po = sel_end ? p1y_i : p0y_i;
      qe = sel_end ? p0x_i : p1x_i;
      qo = sel_end ? p0y_i : p1y_i;
    end else begin
      pe = sel_end ? p1y_i : p0y_i;
      po = sel_end ? p1x_i : p0x_i;
      qe = sel_end ? p0y_i : p1y_i;
      qo = sel_end ? p0x_i : p1x_i;
    end
  end

  logic                        a_vld_q, a_done_q, a_acc_q, a_moved_q, a_sel_q, a_usex_q;
  logic signed [CoordBits-1:0] a_p0x_q, a_p0y_q, a_p1x_q, a_p1y_q, a_edge_q, a_po_q;
  logic signed [DW-1:0]        a_de_q, a_dq_q, a_dd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_done_q  <= done_i | now_acc | now_rej;
    a_acc_q   <= done_i ? acc_i : now_acc;
    a_moved_q <= moved_i | !(done_i | now_acc | now_rej);
    a_sel_q   <= sel_end;
    a_usex_q  <= use_x;
    a_p0x_q   <= p0x_i;
    a_p0y_q   <= p0y_i;
    a_p1x_q   <= p1x_i;
    a_p1y_q   <= p1y_i;
    a_edge_q  <= edge_v;
    a_po_q    <= po;
    a_de_q    <= DW'(edge_v) - DW'(pe);
    a_dq_q    <= DW'(qo) - DW'(po);
    a_dd_q    <= DW'(qe) - DW'(pe);
  end

  // Phase two: magnitude product and sign.
  logic [DW-1:0] abs_de, abs_dq, abs_dd;
  assign abs_de = a_de_q[DW-1] ? DW'(-a_de_q) : DW'(a_de_q);
  assign abs_dq = a_dq_q[DW-1] ? DW'(-a_dq_q) : DW'(a_dq_q);
  assign abs_dd = a_dd_q[DW-1] ? DW'(-a_dd_q) : DW'(a_dd_q);

  logic             b_vld_q, b_neg_q;
  logic [PW-1:0]    b_prod_q;
  logic [DW-1:0]    b_den_q;
  logic [TW-1:0]    b_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_prod_q <= PW'(abs_de) * PW'(abs_dq);
    b_den_q  <= abs_dd;
    b_neg_q  <= (a_de_q[DW-1] ^ a_dq_q[DW-1]) ^ a_dd_q[DW-1];
    b_tag_q  <= {a_done_q, a_acc_q, a_moved_q, a_p0x_q, a_p0y_q, a_p1x_q, a_p1y_q,
                 a_sel_q, a_usex_q, a_edge_q, 1'b0};
  end

  // Phase three: quotient, pipelined.
  logic                  d_vld;
  logic signed [PW:0]    quot;
  logic [TW-1:0]         d_tag;
  logic signed [CoordBits-1:0] d_po_q [PW+1];

  always_ff @(posedge clk_i) begin
    d_po_q[0] <= a_po_q;
  end
  for (genvar k = 0; k < PW; k++) begin : g_po
    always_ff @(posedge clk_i) begin
      d_po_q[k+1] <= d_po_q[k];
    end
  end

  lswc_div #(.NumBits(PW), .DenBits(DW), .TagBits(TW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_vld_q),
    .num_i   (b_prod_q),
    .den_i   (b_den_q),
    .neg_i   (b_neg_q),
    .tag_i   (b_tag_q),
    .valid_o (d_vld),
    .quot_o  (quot),
    .tag_o   (d_tag)
  );

  // Phase four: apply the move.
  logic                        t_done, t_acc, t_moved, t_sel, t_usex;
  logic signed [CoordBits-1:0] t_p0x, t_p0y, t_p1x, t_p1y, t_edge, new_o;
  logic                        t_unused;
  assign {t_done, t_acc, t_moved, t_p0x, t_p0y, t_p1x, t_p1y,
          t_sel, t_usex, t_edge, t_unused} = d_tag;
  assign new_o = CoordBits'(d_po_q[PW] + quot[CoordBits-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    done_o  <= t_done;
    acc_o   <= t_acc;
    moved_o <= t_moved;
    p0x_o   <= t_p0x;
    p0y_o   <= t_p0y;
    p1x_o   <= t_p1x;
    p1y_o   <= t_p1y;
    if (!t_done && !t_unused) begin
      if (!t_sel) begin
        p0x_o <= t_usex ? t_edge : new_o;
        p0y_o <= t_usex ? new_o : t_edge;
      end else begin
        p1x_o <= t_usex ? t_edge : new_o;
        p1y_o <= t_usex ? new_o : t_edge;
      end
    end
  end

endmodule : lswc_step
`default_nettype wire

### rtl/line_segment_window_clipper_core.sv
// Top level of the line segment window clipper: window registers, a chain
// of clip steps and the result stage. Depends on lswc_pkg and lswc_step.
`timescale 1ns / 1ps
`default_nettype none
// A segment is taken on every cycle that start is high; busy is never
// raised. Each segment passes through a fixed chain of nine clip steps and a
// final decision stage before its result appears on done_o; each step holds
// a bit-per-stage intersection divider. Results come in input order, one per
// segment, and the receiver cannot stall them. The window registers are
// written through cfg_valid_i / cfg_ready_o; ready stays low while any
// segment is in flight or start is high, so a window change never lands in
// the middle of a segment.
module line_segment_window_clipper_core #(
  parameter int unsigned COORD_BITS = lswc_pkg::CoordBitsDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [COORD_BITS-1:0]      start_x_i,
  input  wire logic signed [COORD_BITS-1:0]      start_y_i,
  input  wire logic signed [COORD_BITS-1:0]      end_x_i,
  input  wire logic signed [COORD_BITS-1:0]      end_y_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lswc_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  wire logic signed [COORD_BITS-1:0]      cfg_data_i,
  output logic                                   done_o,
  output logic                                   visible_o,
  output logic signed [COORD_BITS-1:0]           clipped_start_x_o,
  output logic signed [COORD_BITS-1:0]           clipped_start_y_o,
  output logic signed [COORD_BITS-1:0]           clipped_end_x_o,
  output logic signed [COORD_BITS-1:0]           clipped_end_y_o,
  output logic                                   was_clipped_o
);
  import lswc_pkg::*;

  localparam int unsigned NStep   = ClipSteps + 1;
  localparam int unsigned Latency = NStep * (2 * (COORD_BITS + 1) + 3) + 1;
  localparam int unsigned CntBits = $clog2(Latency + 2);

  assign busy = 1'b0;

  // Count of segments between the input beat and the result beat.
  logic [CntBits-1:0] inflight_q, inflight_d;
  always_comb begin
    inflight_d = inflight_q;
    if (start && !done_o) begin
      inflight_d = inflight_q + CntBits'(1);
    end else if (!start && done_o) begin
      inflight_d = inflight_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  assign cfg_ready_o = (inflight_q == '0) && !start;

  // Window registers.
  logic signed [COORD_BITS-1:0] x_min_q, y_min_q, x_max_q, y_max_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= '0;
      y_min_q <= '0;
      x_max_q <= COORD_BITS'(639);
      y_max_q <= COORD_BITS'(479);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegXMin: x_min_q <= cfg_data_i;
        RegYMin: y_min_q <= cfg_data_i;
        RegXMax: x_max_q <= cfg_data_i;
        RegYMax: y_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Step chain; the last step only decides, its move is discarded as reject.
  logic                         s_vld [NStep+1];
  logic                         s_done[NStep+1];
  logic                         s_acc [NStep+1];
  logic                         s_mov [NStep+1];
  logic signed [COORD_BITS-1:0] s_p0x [NStep+1];
  logic signed [COORD_BITS-1:0] s_p0y [NStep+1];
  logic signed [COORD_BITS-1:0] s_p1x [NStep+1];
  logic signed [COORD_BITS-1:0] s_p1y [NStep+1];

  assign s_vld[0]  = start;
  assign s_done[0] = 1'b0;
  assign s_acc[0]  = 1'b0;
  assign s_mov[0]  = 1'b0;
  assign s_p0x[0]  = start_x_i;
  assign s_p0y[0]  = start_y_i;
  assign s_p1x[0]  = end_x_i;
  assign s_p1y[0]  = end_y_i;

  for (genvar i = 0; i < NStep; i++) begin : g_step
    lswc_step #(.CoordBits(COORD_BITS)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .x_min_i (x_min_q),
      .y_min_i (y_min_q),
      .x_max_i (x_max_q),
      .y_max_i (y_max_q),
      .valid_i (s_vld[i]),
      .done_i  (s_done[i]),
      .acc_i   (s_acc[i]),
      .moved_i (s_mov[i]),
      .p0x_i   (s_p0x[i]),
      .p0y_i   (s_p0y[i]),
      .p1x_i   (s_p1x[i]),
      .p1y_i   (s_p1y[i]),
      .valid_o (s_vld[i+1]),
      .done_o  (s_done[i+1]),
      .acc_o   (s_acc[i+1]),
      .moved_o (s_mov[i+1]),
      .p0x_o   (s_p0x[i+1]),
      .p0y_o   (s_p0y[i+1]),
      .p1x_o   (s_p1x[i+1]),
      .p1y_o   (s_p1y[i+1])
    );
  end

  // Result beat: undecided after the last step counts as rejected.
  logic keep;
  assign keep = s_done[NStep] & s_acc[NStep];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= s_vld[NStep];
    end
  end

  always_ff @(posedge clk_i) begin
    visible_o         <= keep;
    clipped_start_x_o <= keep ? s_p0x[NStep] : '0;
    clipped_start_y_o <= keep ? s_p0y[NStep] : '0;
    clipped_end_x_o   <= keep ? s_p1x[NStep] : '0;
    clipped_end_y_o   <= keep ? s_p1y[NStep] : '0;
    was_clipped_o     <= keep & s_mov[NStep];
  end

endmodule : line_segment_window_clipper_core
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for line_segment_window_clipper_core.
// Predicts every clipped segment in-line and compares it with the block's
// results; depends on lswc_pkg and the clipper RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import lswc_pkg::*;

  localparam int CW = 16;
  // Fixed pipeline depth given for the clip chain.
  localparam int PIPE_DEPTH = 9 * (2 * (CW + 1) + 3) + 1;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    logic   visible;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   was_clipped;
  } clip_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = RegXMin;
  coord_t cfg_data_i = '0;
  logic done_o, visible_o, was_clipped_o;
  coord_t clipped_start_x_o, clipped_start_y_o, clipped_end_x_o, clipped_end_y_o;

  line_segment_window_clipper_core #(.COORD_BITS(CW)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Window as the block should currently hold it.
  longint win_x_min = 0, win_y_min = 0, win_x_max = 639, win_y_max = 479;

  clip_result_t pending_clips[$];
  int errors = 0;
  int segments_sent = 0, seen_visible = 0, seen_rejected = 0, seen_moved = 0;
  int idle_pct = 0;

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = '0;
    c[OcTop]    = y > win_y_max;
    c[OcBottom] = y < win_y_min;
    c[OcRight]  = x > win_x_max;
    c[OcLeft]   = x < win_x_min;
    return c;
  endfunction

  // Scaled intersection offset, quotient truncated toward zero.
  function automatic longint edge_offset(longint a, longint b, longint c);
    if (c == 0) return 0;
    return (a * b) / c;
  endfunction

  function automatic clip_result_t clip_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    longint px[2], py[2], e;
    logic [3:0] c0, c1, c;
    bit moved, accept;
    int p, q;
    clip_result_t r;
    px[0] = sx; py[0] = sy; px[1] = ex; py[1] = ey;
    moved = 0; accept = 0;
    for (int s = 0; s <= ClipSteps; s++) begin
      c0 = region_code(px[0], py[0]);
      c1 = region_code(px[1], py[1]);
      if ((c0 | c1) == 0) begin
        accept = 1;
        break;
      end
      if ((c0 & c1) != 0 || s == ClipSteps) break;
      p = (c0 != 0) ? 0 : 1;
      q = 1 - p;
      c = (c0 != 0) ? c0 : c1;
      if (c[OcLeft] || c[OcRight]) begin
        e = c[OcLeft] ? win_x_min : win_x_max;
        py[p] += edge_offset(e - px[p], py[q] - py[p], px[q] - px[p]);
        px[p] = e;
      end else begin
        e = c[OcBottom] ? win_y_min : win_y_max;
        px[p] += edge_offset(e - py[p], px[q] - px[p], py[q] - py[p]);
        py[p] = e;
      end
      moved = 1;
    end
    r = '0;
    if (accept) begin
      r.visible = 1'b1;
      r.sx = coord_t'(px[0]); r.sy = coord_t'(py[0]);
      r.ex = coord_t'(px[1]); r.ey = coord_t'(py[1]);
      r.was_clipped = moved;
    end
    return r;
  endfunction

  // Send one segment; the expectation is queued when the beat is taken.
  task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    logic b;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    start_x_i <= sx; start_y_i <= sy; end_x_i <= ex; end_y_i <= ey;
    do begin
      @(negedge clk_i);
      b = busy;
      @(posedge clk_i);
    end while (b);
    pending_clips.push_back(clip_segment(sx, sy, ex, ey));
    segments_sent++;
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_clips.size() != 0) @(posedge clk_i);
  endtask

  // Hold one register write until it is taken; the caller drops valid.
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, coord_t val);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    case (idx)
      RegXMin: win_x_min = val;
      RegYMin: win_y_min = val;
      RegXMax: win_x_max = val;
      default: win_y_max = val;
    endcase
  endtask

  task automatic set_window(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    drain();
    write_reg(RegXMin, x0);
    write_reg(RegYMin, y0);
    write_reg(RegXMax, x1);
    write_reg(RegYMax, y1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Coordinate near the window span on one axis, or anywhere at all.
  function automatic coord_t pick_coord(longint lo, longint hi);
    longint a, b, span, v;
    if ($urandom_range(9) < 3) return coord_t'($urandom);
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = b - a + 8;
    v = a - span / 2 + longint'($urandom_range(32'(2 * span)));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return coord_t'(v);
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      send_segment(pick_coord(win_x_min, win_x_max), pick_coord(win_y_min, win_y_max),
                   pick_coord(win_x_min, win_x_max), pick_coord(win_y_min, win_y_max));
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  // Inside, each side, crossings, vertical and horizontal lines, extremes.
  task automatic test_directed;
    idle_pct = 0;
    send_segment(10, 10, 600, 400);
    send_segment(-5, 100, -50, 200);
    send_segment(700, 100, 800, 200);
    send_segment(100, -1, 200, -30);
    send_segment(100, 480, 200, 900);
    send_segment(-100, 240, 740, 240);
    send_segment(320, -100, 320, 600);
    send_segment(-100, -100, 800, 600);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-32768, 240, 32767, 240);
    send_segment(0, 0, 639, 479);
    send_segment(639, 479, 639, 479);
    send_segment(-1, 480, 640, -1);
    send_segment(-10, 470, 10, 500);
    send_segment(630, -5, 650, 5);
    send_segment(32767, 32767, 32767, 32767);
    send_segment(-32768, -32768, -32768, -32768);
    send_segment(-200, 100, 100, 700);
  endtask

  task automatic test_window_extremes;
    set_window(-32768, -32768, 32767, 32767);
    send_random(60);
    set_window(0, 0, 0, 0);
    send_segment(-5, 0, 5, 0);
    send_segment(-3, -3, 3, 3);
    send_random(60);
    set_window(100, 100, -100, -100);
    send_segment(0, 0, 0, 0);
    send_random(60);
    set_window(32767, 32767, 32767, 32767);
    send_random(40);
    set_window(-32768, -32768, -32768, -32768);
    send_random(40);
  endtask

  task automatic test_random_windows;
    int phase_idle[4] = '{0, 62, 28, 62};
    coord_t x0, y0;
    for (int ph = 0; ph < 4; ph++) begin
      x0 = coord_t'($urandom_range(4000) - 2000);
      y0 = coord_t'($urandom_range(4000) - 2000);
      set_window(x0, y0, x0 + coord_t'($urandom_range(3000)),
                 y0 + coord_t'($urandom_range(3000)));
      idle_pct = phase_idle[ph];
      send_random(160);
    end
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk_i) begin
    clip_result_t want;
    if (rst_ni && done_o) begin
      if (pending_clips.size() == 0) begin
        $display("%0t: unexpected result, nothing pending", $time);
        errors++;
      end else begin
        want = pending_clips.pop_front();
        if (visible_o !== want.visible || clipped_start_x_o !== want.sx ||
            clipped_start_y_o !== want.sy || clipped_end_x_o !== want.ex ||
            clipped_end_y_o !== want.ey || was_clipped_o !== want.was_clipped) begin
          $display("%0t: mismatch expected vis=%0d s=(%0d,%0d) e=(%0d,%0d) clip=%0d",
                   $time, want.visible, want.sx, want.sy, want.ex, want.ey,
                   want.was_clipped);
          $display("%0t:          actual   vis=%0d s=(%0d,%0d) e=(%0d,%0d) clip=%0d",
                   $time, visible_o, clipped_start_x_o, clipped_start_y_o,
                   clipped_end_x_o, clipped_end_y_o, was_clipped_o);
          errors++;
        end
        if (want.visible) seen_visible++; else seen_rejected++;
        if (want.was_clipped) seen_moved++;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    idle_pct = 62;
    send_random(60);
    test_window_extremes();
    test_random_windows();
    set_window(0, 0, 639, 479);
    idle_pct = 28;
    send_random(60);
    drain();
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (pending_clips.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_clips.size());
      errors++;
    end
    $display("Sent %0d segments over several windows: %0d visible (%0d clipped), %0d rejected.",
             segments_sent, seen_visible, seen_moved, seen_rejected);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
